>>> src/rse_pkg.sv
// Shared types and constants for the RTT smoothing estimator.
`default_nettype none

package rse_pkg;

	// Estimate values after reset, in microseconds.
	localparam logic [31:0] DEFAULT_SMOOTHED_US = 32'd100000;
	localparam logic [31:0] DEFAULT_VARIATION_US = 32'd50000;
	localparam logic [31:0] MIN_NAK_RESET_US = 32'd20000;

	// Depth of the queue between front and back.
	localparam int RSE_QUEUE_DEPTH = 2;

	// Command codes of an input word.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_PEER = 1'b1;

	// Input word.
	typedef struct packed {
		logic        cmd;
		logic [31:0] sample_us;
		logic [31:0] peer_smoothed_us;
		logic [31:0] peer_variation_us;
		logic        bidirectional;
	} req_t;

	// Result word.
	typedef struct packed {
		logic [31:0] smoothed_us;
		logic [31:0] variation_us;
		logic        has_sample;
		logic [31:0] nak_interval_us;
		logic        applied;
	} rsp_t;

	// Operation decided by the front.
	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_PEER   = 2'd2
	} op_t;

	// Queue entry: classified operation with its operands.
	typedef struct packed {
		op_t         op;
		logic [31:0] value;
		logic [31:0] var_value;
		logic        is_default;
		logic        bidir;
	} qentry_t;

endpackage

`default_nettype wire

>>> src/rse_if.sv
// Channel interfaces of the RTT smoothing estimator.
`default_nettype none

interface rse_req_if import rse_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rse_rsp_if import rse_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rse_cfg_if import rse_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/rse_front.sv
// Front end: accepts input words and classifies them into queue entries.
`default_nettype none

module rse_front import rse_pkg::*; (
	rse_req_if.sink  req,
	input  logic     full,
	output logic     push,
	output qentry_t  push_entry
);

	// Accept whenever the queue has room.
	assign req.ready = !full;
	assign push = req.valid && !full;

	// Classify the word; zero values turn into no-ops.
	always_comb begin
		push_entry.bidir = req.data.bidirectional;
		push_entry.is_default = (req.data.peer_smoothed_us == DEFAULT_SMOOTHED_US) &&
			(req.data.peer_variation_us == DEFAULT_VARIATION_US);
		if (req.data.cmd == CMD_SAMPLE) begin
			push_entry.value = req.data.sample_us;
			push_entry.var_value = {1'b0, req.data.sample_us[31:1]};
			push_entry.op = (req.data.sample_us != '0) ? OP_SAMPLE : OP_NONE;
		end else begin
			push_entry.value = req.data.peer_smoothed_us;
			push_entry.var_value = req.data.peer_variation_us;
			push_entry.op = (req.data.peer_smoothed_us != '0) ? OP_PEER : OP_NONE;
		end
	end

endmodule

`default_nettype wire

>>> src/rse_queue.sv
// Small queue that decouples the front end from the back end.
`default_nettype none

module rse_queue import rse_pkg::*; #(
	parameter int DEPTH = RSE_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qentry_t push_entry,
	output logic    full,
	output logic    q_valid,
	output qentry_t q_entry,
	input  logic    pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qentry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_entry = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/rse_back.sv
// Back end: applies queued operations to the estimate and forms result words.
`default_nettype none

module rse_back import rse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	rse_cfg_if.sink  cfg,
	input  logic     q_valid,
	input  qentry_t  q_entry,
	output logic     pop,
	rse_rsp_if.source rsp
);

	logic [31:0] min_nak_q;
	logic [31:0] smoothed_q;
	logic [31:0] variation_q;
	logic        seeded_q;

	logic        valid_s1;
	logic [31:0] smoothed_s1;
	logic [31:0] variation_s1;
	logic        seeded_s1;
	logic        applied_s1;

	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic        out_free;
	logic        s1_free;

	logic [31:0] diff;
	logic [33:0] var_sum;
	logic [34:0] sm_sum;
	logic [31:0] next_s;
	logic [31:0] next_v;
	logic        next_seeded;
	logic        applied;

	logic [34:0] nak_sum;
	logic [33:0] nak_half;
	logic [31:0] nak_val;

	// Stage flow control.
	assign out_free = !rsp_valid_q || rsp.ready;
	assign s1_free = !valid_s1 || out_free;
	assign pop = q_valid && s1_free;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_nak_q <= MIN_NAK_RESET_US;
		end else if (cfg.valid) begin
			min_nak_q <= cfg.data;
		end
	end

	// Blend terms: v = (3v + |s - x|) / 4 and s = (7s + x) / 8.
	assign diff = (smoothed_q > q_entry.value) ? smoothed_q - q_entry.value
		: q_entry.value - smoothed_q;
	assign var_sum = {1'b0, variation_q, 1'b0} + {2'b00, variation_q} + {2'b00, diff};
	assign sm_sum = {smoothed_q, 3'b000} - {3'b000, smoothed_q} + {3'b000, q_entry.value};

	// Resolve the operation against the current seeded flag.
	always_comb begin
		next_s = smoothed_q;
		next_v = variation_q;
		next_seeded = seeded_q;
		applied = 1'b0;
		case (q_entry.op)
			OP_SAMPLE: begin
				applied = 1'b1;
				next_seeded = 1'b1;
				if (!seeded_q) begin
					next_s = q_entry.value;
					next_v = q_entry.var_value;
				end else begin
					next_s = sm_sum[34:3];
					next_v = var_sum[33:2];
				end
			end
			OP_PEER: begin
				if (!seeded_q) begin
					if (!q_entry.is_default) begin
						next_s = q_entry.value;
						next_v = q_entry.var_value;
						next_seeded = 1'b1;
						applied = 1'b1;
					end
				end else if (!q_entry.bidir) begin
					next_s = q_entry.value;
					next_v = q_entry.var_value;
					applied = 1'b1;
				end else if (!q_entry.is_default) begin
					next_s = sm_sum[34:3];
					next_v = var_sum[33:2];
					applied = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Estimate state and execute-stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= DEFAULT_SMOOTHED_US;
			variation_q <= DEFAULT_VARIATION_US;
			seeded_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (pop) begin
				smoothed_q <= next_s;
				variation_q <= next_v;
				seeded_q <= next_seeded;
			end
			if (s1_free) begin
				valid_s1 <= pop;
			end
		end
	end

	// Execute-stage payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			smoothed_s1 <= next_s;
			variation_s1 <= next_v;
			seeded_s1 <= next_seeded;
			applied_s1 <= applied;
		end
	end

	// NAK interval: max(min, (s + 4v) / 2), saturated to 32 bits.
	assign nak_sum = {3'b000, smoothed_s1} + {1'b0, variation_s1, 2'b00};
	assign nak_half = nak_sum[34:1];
	always_comb begin
		if (nak_half[33:32] != 2'b00) begin
			nak_val = '1;
		end else if (nak_half[31:0] < min_nak_q) begin
			nak_val = min_nak_q;
		end else begin
			nak_val = nak_half[31:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			rsp_q.smoothed_us <= smoothed_s1;
			rsp_q.variation_us <= variation_s1;
			rsp_q.has_sample <= seeded_s1;
			rsp_q.nak_interval_us <= nak_val;
			rsp_q.applied <= applied_s1;
		end
	end

endmodule

`default_nettype wire

>>> src/rtt_smoothing_estimator.sv
// Top level of the RTT smoothing estimator.
//
// Channels: req carries one word per RTT event (own sample or peer estimate),
// rsp returns one word per req word with the estimate after that event, the
// has-sample flag, the NAK interval and whether the event changed the state.
// cfg writes the minimum NAK interval; it is always ready and must only be
// written while no words are in flight.
// Path: a word accepted on req passes through the queue, the execute stage
// and the output register, in that order, before it is valid on rsp.
// Throughput: one word per cycle while rsp is not stalled; the estimate update
// is a read-modify-write of the state registers in the back end as each word pops.
// Reset: arst_n clears the queue and pipeline, sets the estimate to
// 100000/50000 us unseeded and the minimum NAK interval to 20000 us.
// Stall: when rsp.ready is low the output register holds its word, the
// execute stage and then the queue fill, and req.ready drops once the queue
// is full. No word is lost or repeated.
`default_nettype none

module rtt_smoothing_estimator import rse_pkg::*; #(
	parameter int QUEUE_DEPTH = RSE_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	rse_cfg_if.sink   cfg,
	rse_req_if.sink   req,
	rse_rsp_if.source rsp
);

	logic    push;
	qentry_t push_entry;
	logic    full;
	logic    q_valid;
	qentry_t q_entry;
	logic    pop;

	// Classify incoming words.
	rse_front u_front (
		.req       (req),
		.full      (full),
		.push      (push),
		.push_entry(push_entry)
	);

	// Decoupling queue.
	rse_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.pop       (pop)
	);

	// Apply updates and produce results.
	rse_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

>>> src/rse_checker.sv
// Port-level checks for the RTT smoothing estimator and their binding.
`default_nettype none

module rse_checker import rse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_word
);

	// A stalled result word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
		else $error("result word changed while stalled");

	// Any applied update leaves the estimate seeded.
	a_applied_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.applied |-> rsp_word.has_sample)
		else $error("applied update without has_sample");

	// Before the first real estimate the defaults are reported.
	a_unseeded_default: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_word.has_sample |->
			rsp_word.smoothed_us == DEFAULT_SMOOTHED_US &&
			rsp_word.variation_us == DEFAULT_VARIATION_US)
		else $error("unseeded estimate differs from defaults");

	// The NAK interval never drops below half the smoothed RTT.
	a_nak_floor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_word.nak_interval_us >= {1'b0, rsp_word.smoothed_us[31:1]})
		else $error("NAK interval below half the smoothed RTT");

endmodule

bind rtt_smoothing_estimator rse_checker u_rse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_word (rsp.data)
);

`default_nettype wire
